// ===== hw/rtl/fdfr_pkg.sv =====
// Shared types and constants for the framed decimal field receiver.
// Used by the front end, the item queue, the parser back end and the top level.
package fdfr_pkg;

	localparam int BUFFER_CHARS = 100;
	localparam int CNT_W = $clog2(BUFFER_CHARS);
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] REG_START_MARKER = 2'd0;
	localparam logic [1:0] REG_END_MARKER = 2'd1;
	localparam logic [1:0] REG_SEPARATOR = 2'd2;

	localparam logic [7:0] RST_START_MARKER = 8'd60;
	localparam logic [7:0] RST_END_MARKER = 8'd62;
	localparam logic [7:0] RST_SEPARATOR = 8'd44;

	localparam logic [7:0] CHR_ZERO = 8'd48;
	localparam logic [7:0] CHR_NINE = 8'd57;
	localparam logic [7:0] CHR_PLUS = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;
	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_TAB = 8'd9;
	localparam logic [7:0] CHR_CR = 8'd13;
	localparam logic [7:0] CHR_NUL = 8'd0;

	typedef enum logic {
		ITEM_PAYLOAD,
		ITEM_END
	} item_kind_t;

	// A classified byte as handed from the front end to the parser.
	typedef struct packed {
		item_kind_t kind;
		logic is_nul;
		logic is_sep;
		logic is_space;
		logic is_plus;
		logic is_minus;
		logic is_digit;
		logic [3:0] digit_val;
	} item_t;

endpackage

// ===== hw/rtl/framed_decimal_field_receiver_top.sv =====
// An accepted end marker is queued, then its pop loads the result register and out_valid.
// Throughput: one byte per cycle while the item queue is not full; the four-entry
// item queue and the result register let input and output stall independently.
// Reset (arst_n low, asynchronous): markers return to '<' '>' ',', frame and parse
// state clear, last heading is zero, no result is pending.
// Top level of the framed decimal field receiver; uses fdfr_pkg and the fdfr_* modules.
module framed_decimal_field_receiver_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic signed [15:0] heading,
	output logic number_found,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	import fdfr_pkg::*;

	item_t push_item;
	item_t head_item;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;

	fdfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	fdfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(push_item),
		.pop(q_pop),
		.head_item(head_item),
		.empty(q_empty),
		.full(q_full)
	);

	fdfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head_item(head_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.heading(heading),
		.number_found(number_found)
	);

endmodule

// ===== hw/rtl/fdfr_front.sv =====
// Front end: configuration registers, frame tracking and byte classification.
// Depends on fdfr_pkg; feeds fdfr_queue.
module fdfr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic q_full,
	output logic q_push,
	output fdfr_pkg::item_t q_item
);
	import fdfr_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic [7:0] separator_q;
	logic in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic accept;
	logic is_end;
	logic has_room;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign is_end = (rx_byte == end_marker_q);
	assign has_room = (count_q < CNT_W'(BUFFER_CHARS - 1));

	// Within a frame, payload bytes past the first BUFFER_CHARS - 1 are dropped; the end marker always passes.
	assign q_push = accept && in_frame_q && (is_end || has_room);

	always_comb begin
		q_item.kind = is_end ? ITEM_END : ITEM_PAYLOAD;
		q_item.is_nul = (rx_byte == CHR_NUL);
		q_item.is_sep = (rx_byte == separator_q);
		q_item.is_space = (rx_byte == CHR_SPACE) || (rx_byte >= CHR_TAB && rx_byte <= CHR_CR);
		q_item.is_plus = (rx_byte == CHR_PLUS);
		q_item.is_minus = (rx_byte == CHR_MINUS);
		q_item.is_digit = (rx_byte >= CHR_ZERO) && (rx_byte <= CHR_NINE);
		q_item.digit_val = rx_byte[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= RST_START_MARKER;
			end_marker_q <= RST_END_MARKER;
			separator_q <= RST_SEPARATOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER: end_marker_q <= cfg_data;
				REG_SEPARATOR: separator_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == start_marker_q) begin
					in_frame_q <= 1'b1;
					count_q <= '0;
				end
			end else if (is_end) begin
				in_frame_q <= 1'b0;
				count_q <= '0;
			end else if (has_room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/fdfr_queue.sv =====
// Short FIFO of classified items between the front end and the parser.
// Depends on fdfr_pkg.
module fdfr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fdfr_pkg::item_t push_item,
	input logic pop,
	output fdfr_pkg::item_t head_item,
	output logic empty,
	output logic full
);
	import fdfr_pkg::*;

	item_t slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == QCNT_W'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/fdfr_back.sv =====
// Parser back end: token state machine, decimal accumulator and result register.
// Depends on fdfr_pkg; drains fdfr_queue.
module fdfr_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input fdfr_pkg::item_t head_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic signed [15:0] heading,
	output logic number_found
);
	import fdfr_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIPSEP,
		PH_LEAD,
		PH_DIGITS,
		PH_DONE,
		PH_EMPTY
	} phase_t;

	phase_t phase_q;
	logic negative_q;
	logic [15:0] acc_q;
	logic [15:0] last_heading_q;
	logic out_valid_q;
	logic [15:0] heading_q;
	logic found_q;
	logic out_free;
	logic found;
	logic [15:0] value;
	logic [15:0] acc_next;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop = !q_empty && (head_item.kind == ITEM_PAYLOAD || out_free);
	assign found = (phase_q == PH_LEAD) || (phase_q == PH_DIGITS) || (phase_q == PH_DONE);
	assign value = negative_q ? (16'd0 - acc_q) : acc_q;
	assign acc_next = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + 16'(head_item.digit_val);

	assign out_valid = out_valid_q;
	assign heading = heading_q;
	assign number_found = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIPSEP;
			negative_q <= 1'b0;
			acc_q <= '0;
			last_heading_q <= '0;
			out_valid_q <= 1'b0;
			heading_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (head_item.kind == ITEM_END) begin
					out_valid_q <= 1'b1;
					found_q <= found;
					heading_q <= found ? value : last_heading_q;
					if (found) begin
						last_heading_q <= value;
					end
					phase_q <= PH_SKIPSEP;
					negative_q <= 1'b0;
					acc_q <= '0;
				end else begin
					case (phase_q)
						PH_SKIPSEP, PH_LEAD: begin
							// A byte other than NUL that ends the separator run is judged as a lead byte.
							if (phase_q == PH_SKIPSEP && head_item.is_nul) begin
								phase_q <= PH_EMPTY;
							end else if (phase_q == PH_SKIPSEP && head_item.is_sep) begin
								phase_q <= PH_SKIPSEP;
							end else if (head_item.is_nul || head_item.is_sep) begin
								phase_q <= PH_DONE;
							end else if (head_item.is_space) begin
								phase_q <= PH_LEAD;
							end else if (head_item.is_plus) begin
								phase_q <= PH_DIGITS;
							end else if (head_item.is_minus) begin
								negative_q <= 1'b1;
								phase_q <= PH_DIGITS;
							end else if (head_item.is_digit) begin
								acc_q <= 16'(head_item.digit_val);
								phase_q <= PH_DIGITS;
							end else begin
								phase_q <= PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (!head_item.is_sep && head_item.is_digit) begin
								acc_q <= acc_next;
							end else begin
								phase_q <= PH_DONE;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

// ===== hw/rtl/fdfr_checker.sv =====
// Port-level checks for the framed decimal field receiver, bound to the top level.
// Depends only on the top-level ports.
module fdfr_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] heading,
	input logic number_found,
	input logic cfg_valid,
	input logic cfg_ready
);

	logic [15:0] last_out_q;

	// Tracks the heading of the most recently delivered item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_out_q <= '0;
		end else if (out_valid && out_ready) begin
			last_out_q <= heading;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(number_found))
		else $error("result item changed while stalled");

	a_empty_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !number_found |-> heading == last_out_q)
		else $error("frame without token did not repeat previous heading");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result pending right after reset");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind framed_decimal_field_receiver_top fdfr_checker u_fdfr_checker (.*);
